// ===== sv/dwt10_pkg.sv =====
// Shared types, constants and filter taps for the db10 analysis stage.
package dwt10_pkg;

  localparam int TAPS     = 20;
  localparam int MIRROR   = 19;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int IDX_W    = 16;
  localparam int POS_W    = 17;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 40;
  localparam int MAX_LEN  = 65535;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  // Work kinds passed from the front to the back.
  typedef enum logic [1:0] {
    K_SHORT  = 2'd0,
    K_START  = 2'd1,
    K_SAMPLE = 2'd2
  } kind_t;

  typedef struct packed {
    sample_t sample;
    logic    last;
    kind_t   kind;
  } cmd_t;

  // Status from the back to the front.
  typedef struct packed {
    logic sig_done;
    logic busy;
  } back_stat_t;

  // High-pass and low-pass taps in Q1.15.
  localparam logic signed [15:0] HP_TAPS [TAPS] = '{
    -16'sd875, 16'sd6167, -16'sd17275, 16'sd22561, -16'sd9214, -16'sd8185,
    16'sd6419, 16'sd4175, -16'sd3051, -16'sd2340, 16'sd967, 16'sd1088,
    -16'sd118, -16'sd351, -16'sd46, 16'sd66, 16'sd23, -16'sd3, -16'sd3, 16'sd0
  };
  localparam logic signed [15:0] LP_TAPS [TAPS] = '{
    16'sd0, 16'sd3, -16'sd3, -16'sd23, 16'sd66, 16'sd46, -16'sd351, 16'sd118,
    16'sd1088, -16'sd967, -16'sd2340, 16'sd3051, 16'sd4175, -16'sd6419,
    -16'sd8185, 16'sd9214, 16'sd22561, 16'sd17275, 16'sd6167, 16'sd875
  };

endpackage

// ===== sv/dwt10_ifs.sv =====
// Valid/ready channel interfaces for samples and coefficient pairs.
interface dwt10_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [15:0]        sample;
  logic                      last;
  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface dwt10_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [17:0]        high_coef;
  logic signed [17:0]        low_coef;
  logic [15:0]               coef_index;
  logic                      final_res;
  logic                      too_short;
  modport source (output valid, high_coef, low_coef, coef_index, final_res, too_short,
                  input ready);
  modport sink   (input valid, high_coef, low_coef, coef_index, final_res, too_short,
                  output ready);
endinterface

// ===== sv/dwt10_front.sv =====
// Front end: takes samples, keeps head and tail history, queues work for the back.
module dwt10_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  dwt10_pkg::sample_t      in_sample,
  input  logic                    in_last,
  output logic                    q_push,
  output dwt10_pkg::cmd_t         q_data,
  input  logic                    q_full,
  input  dwt10_pkg::back_stat_t   stat,
  output dwt10_pkg::sample_t      head_o [dwt10_pkg::MIRROR],
  output dwt10_pkg::sample_t      tail_o [dwt10_pkg::MIRROR]
);

  dwt10_pkg::sample_t    head_r [dwt10_pkg::MIRROR];
  dwt10_pkg::sample_t    tail_r [dwt10_pkg::MIRROR];
  logic [15:0]           count_r;
  logic                  wait_r;
  logic                  acc;
  logic                  last_eff;

  assign in_ready = !wait_r && !q_full;
  assign acc      = in_valid && in_ready;
  assign last_eff = in_last || (count_r >= 16'(dwt10_pkg::MAX_LEN - 1));

  // Classify the item by its place in the signal.
  always_comb begin
    q_push        = 1'b0;
    q_data.sample = in_sample;
    q_data.last   = last_eff;
    q_data.kind   = dwt10_pkg::K_SAMPLE;
    if (acc) begin
      if (count_r < 16'(dwt10_pkg::MIRROR - 1)) begin
        q_push      = last_eff;
        q_data.kind = dwt10_pkg::K_SHORT;
      end else if (count_r == 16'(dwt10_pkg::MIRROR - 1)) begin
        q_push      = 1'b1;
        q_data.kind = dwt10_pkg::K_START;
      end else begin
        q_push      = 1'b1;
      end
    end
  end

  // History stores are pure payload.
  always_ff @(posedge clk) begin
    if (acc) begin
      tail_r[0] <= in_sample;
      for (int i = 1; i < dwt10_pkg::MIRROR; i++) tail_r[i] <= tail_r[i-1];
      if (count_r < 16'(dwt10_pkg::MIRROR)) head_r[count_r[4:0]] <= in_sample;
    end
  end

  // Sample count and the hold after a signal closes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wait_r  <= 1'b0;
    end else begin
      if (acc) begin
        if (last_eff) begin
          count_r <= '0;
          wait_r  <= 1'b1;
        end else begin
          count_r <= count_r + 16'd1;
        end
      end else if (stat.sig_done) begin
        wait_r <= 1'b0;
      end
    end
  end

  assign head_o = head_r;
  assign tail_o = tail_r;

endmodule

// ===== sv/dwt10_queue.sv =====
// Short command queue between the front and the back.
module dwt10_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dwt10_pkg::cmd_t   push_data,
  output logic              full,
  input  logic              pop,
  output dwt10_pkg::cmd_t   pop_data,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dwt10_pkg::cmd_t  mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= push_data;
  end

  // Pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (pop && !empty) rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      cnt_r <= cnt_r + CW'(push && !full) - CW'(pop && !empty);
    end
  end

endmodule

// ===== sv/dwt10_back.sv =====
// Back end: extends the signal, runs the two filters by serial MAC, drives results.
module dwt10_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  dwt10_pkg::cmd_t         q_data,
  output logic                    q_pop,
  input  dwt10_pkg::sample_t      head_i [dwt10_pkg::MIRROR],
  input  dwt10_pkg::sample_t      tail_i [dwt10_pkg::MIRROR],
  output dwt10_pkg::back_stat_t   stat,
  dwt10_out_if.source             out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_PUSH, S_MAC, S_OUT, S_ERR} state_t;
  typedef enum logic [2:0] {PH_HREV, PH_HFWD, PH_SMP, PH_TAIL, PH_DONE} phase_t;

  state_t                     st_r;
  phase_t                     phase_r;
  dwt10_pkg::cmd_t            ent_r;
  logic [4:0]                 p_r;
  logic [dwt10_pkg::POS_W-1:0] pos_r;
  dwt10_pkg::sample_t         tap_r [dwt10_pkg::TAPS];
  logic [4:0]                 mac_r;
  logic signed [dwt10_pkg::PROD_W-1:0] prod_h_r, prod_l_r;
  logic signed [dwt10_pkg::ACC_W-1:0]  acc_h_r, acc_l_r;
  logic                       fin_r;
  logic [15:0]                ocnt_r;
  logic                       done_r;
  logic                       ov_r;
  dwt10_pkg::coef_t           oh_r, ol_r;
  logic [15:0]                oi_r;
  logic                       of_r, os_r;
  dwt10_pkg::sample_t         push_val;
  logic                       out_free;

  // Round by 15 bits to nearest and saturate to the coefficient range.
  function automatic dwt10_pkg::coef_t round_sat(logic signed [dwt10_pkg::ACC_W-1:0] a);
    logic signed [dwt10_pkg::ACC_W-1:0] v;
    logic signed [dwt10_pkg::ACC_W-1:0] q;
    v = a + dwt10_pkg::ACC_W'(16384);
    q = v >>> 15;
    if (q > dwt10_pkg::ACC_W'(131071)) return dwt10_pkg::COEF_W'(131071);
    if (q < -dwt10_pkg::ACC_W'(131072)) return dwt10_pkg::coef_t'(-131072);
    return q[dwt10_pkg::COEF_W-1:0];
  endfunction

  // Value of the extended signal for this push.
  always_comb begin
    case (phase_r)
      PH_HREV: push_val = head_i[5'(dwt10_pkg::MIRROR - 1) - p_r];
      PH_HFWD: push_val = head_i[p_r];
      PH_SMP:  push_val = ent_r.sample;
      PH_TAIL: push_val = tail_i[p_r];
      default: push_val = '0;
    endcase
  end

  assign out_free = !ov_r || out_ch.ready;
  assign q_pop    = (st_r == S_IDLE) && !q_empty;
  assign stat.sig_done = done_r;
  assign stat.busy     = (st_r != S_IDLE);

  assign out_ch.valid      = ov_r;
  assign out_ch.high_coef  = oh_r;
  assign out_ch.low_coef   = ol_r;
  assign out_ch.coef_index = oi_r;
  assign out_ch.final_res  = of_r;
  assign out_ch.too_short  = os_r;

  // Sequencer, tap line, MAC and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      phase_r <= PH_DONE;
      ov_r    <= 1'b0;
      ocnt_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      // The signal is closed when its last push ends or its error result is loaded.
      done_r <= (st_r == S_PUSH && phase_r == PH_DONE && ent_r.last) ||
                (st_r == S_ERR && out_free);
      if (ov_r && out_ch.ready && st_r != S_OUT && st_r != S_ERR) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            ent_r <= q_data;
            p_r   <= '0;
            case (q_data.kind)
              dwt10_pkg::K_SHORT: st_r <= S_ERR;
              dwt10_pkg::K_START: begin
                phase_r <= PH_HREV;
                pos_r   <= '0;
                st_r    <= S_PUSH;
              end
              default: begin
                phase_r <= PH_SMP;
                st_r    <= S_PUSH;
              end
            endcase
          end
        end
        S_PUSH: begin
          if (phase_r == PH_DONE) begin
            st_r <= S_IDLE;
            if (ent_r.last) ocnt_r <= '0;
          end else begin
            tap_r[0] <= push_val;
            for (int i = 1; i < dwt10_pkg::TAPS; i++) tap_r[i] <= tap_r[i-1];
            pos_r <= pos_r + dwt10_pkg::POS_W'(1);
            fin_r <= (phase_r == PH_TAIL) && (p_r >= 5'd17);
            // Step through the mirror and sample phases.
            case (phase_r)
              PH_HREV: begin
                if (p_r == 5'(dwt10_pkg::MIRROR - 1)) begin
                  phase_r <= PH_HFWD;
                  p_r     <= '0;
                end else p_r <= p_r + 5'd1;
              end
              PH_HFWD: begin
                if (p_r == 5'(dwt10_pkg::MIRROR - 1)) begin
                  phase_r <= ent_r.last ? PH_TAIL : PH_DONE;
                  p_r     <= '0;
                end else p_r <= p_r + 5'd1;
              end
              PH_SMP: begin
                phase_r <= ent_r.last ? PH_TAIL : PH_DONE;
                p_r     <= '0;
              end
              PH_TAIL: begin
                if (p_r == 5'(dwt10_pkg::MIRROR - 1)) phase_r <= PH_DONE;
                else p_r <= p_r + 5'd1;
              end
              default: phase_r <= PH_DONE;
            endcase
            // A pair is kept at every even position from the tap count on.
            if (pos_r >= dwt10_pkg::POS_W'(dwt10_pkg::TAPS) && !pos_r[0]) begin
              st_r    <= S_MAC;
              mac_r   <= '0;
              acc_h_r <= '0;
              acc_l_r <= '0;
            end
          end
        end
        S_MAC: begin
          if (mac_r < 5'(dwt10_pkg::TAPS)) begin
            prod_h_r <= tap_r[mac_r] * dwt10_pkg::HP_TAPS[mac_r];
            prod_l_r <= tap_r[mac_r] * dwt10_pkg::LP_TAPS[mac_r];
          end
          if (mac_r != '0) begin
            acc_h_r <= acc_h_r + dwt10_pkg::ACC_W'(prod_h_r);
            acc_l_r <= acc_l_r + dwt10_pkg::ACC_W'(prod_l_r);
          end
          if (mac_r == 5'(dwt10_pkg::TAPS)) st_r <= S_OUT;
          else mac_r <= mac_r + 5'd1;
        end
        S_OUT: begin
          if (out_free) begin
            ov_r   <= 1'b1;
            oh_r   <= round_sat(acc_h_r);
            ol_r   <= round_sat(acc_l_r);
            oi_r   <= ocnt_r;
            of_r   <= fin_r;
            os_r   <= 1'b0;
            ocnt_r <= ocnt_r + 16'd1;
            st_r   <= S_PUSH;
          end
        end
        S_ERR: begin
          if (out_free) begin
            ov_r   <= 1'b1;
            oh_r   <= '0;
            ol_r   <= '0;
            oi_r   <= '0;
            of_r   <= 1'b1;
            os_r   <= 1'b1;
            ocnt_r <= '0;
            st_r   <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // An error result always closes its signal.
  a_short_final: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && os_r) |-> of_r) else $error("error result without final mark");

  // The MAC counter stays within the tap count.
  a_mac_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MAC) |-> (mac_r <= 5'(dwt10_pkg::TAPS))) else $error("MAC counter overrun");

  // The tail mirror runs only for an item that closes the signal.
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_PUSH && phase_r == PH_TAIL) |-> ent_r.last) else $error("tail without last");

endmodule

// ===== sv/dwt_db10_analysis_stage.sv =====
// Top level of the one-level db10 wavelet analysis stage.
// Each sample item is taken while the command queue has room. The back end handles each
// queued sample item by dequeue, push and close, and computes each coefficient pair on its
// single shared multiply-accumulate pair before loading it into the output register; the
// first 19 samples are pushed as 38 mirrored values and the last item adds 19 tail
// pushes. After an item with last, no sample is taken until every pair of that signal
// has been loaded into the back end's output register.
module dwt_db10_analysis_stage #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  dwt10_in_if.sink      in_ch,
  dwt10_out_if.source   out_ch
);

  logic                    q_push, q_full, q_pop, q_empty;
  dwt10_pkg::cmd_t         q_wdata, q_rdata;
  dwt10_pkg::back_stat_t   stat;
  dwt10_pkg::sample_t      head [dwt10_pkg::MIRROR];
  dwt10_pkg::sample_t      tail [dwt10_pkg::MIRROR];

  dwt10_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_sample(in_ch.sample),
    .in_last  (in_ch.last),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full),
    .stat     (stat),
    .head_o   (head),
    .tail_o   (tail)
  );

  dwt10_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  dwt10_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(q_empty),
    .q_data (q_rdata),
    .q_pop  (q_pop),
    .head_i (head),
    .tail_i (tail),
    .stat   (stat),
    .out_ch (out_ch)
  );

endmodule

// ===== bench/tb_dwt10_ifs.sv =====
// Note: the channel interfaces come from the RTL file sv/dwt10_ifs.sv; this file adds the bench-side shared types.
`timescale 1ns / 100ps
package tb_dwt10_pkg;

  // One expected coefficient pair, or the error result for a short signal.
  typedef struct {
    logic signed [17:0] high_coef;
    logic signed [17:0] low_coef;
    logic [15:0]        coef_index;
    logic               final_res;
    logic               too_short;
  } coef_pair_t;

  // One row of the directed stimulus; chk_first asks for a typed-in check of the first pair.
  typedef struct {
    logic signed [15:0] sample;
    logic               last;
    logic               chk_first;
    coef_pair_t         first_pair;
  } stim_row_t;
endpackage

// ===== bench/tb_dwt_db10_analysis_stage.sv =====
// Self-checking testbench for the db10 analysis stage with an internal predictor.
`timescale 1ns / 100ps
module tb_dwt_db10_analysis_stage;

  localparam int WATCHDOG_LIMIT = 40000;

  logic clk;
  logic rst_n;
  dwt10_in_if  in_ch ();
  dwt10_out_if out_ch ();

  dwt_db10_analysis_stage dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Predictor state for the signal in progress.
  logic signed [15:0] head_buf [dwt10_pkg::MIRROR];
  logic signed [15:0] recent [dwt10_pkg::MIRROR];
  logic signed [15:0] window [dwt10_pkg::TAPS];
  int unsigned taken_cnt;
  int unsigned pair_cnt;

  tb_dwt10_pkg::coef_pair_t pending_pairs [$];
  int  error_cnt;
  bit  stim_done;
  bit  no_idle;
  int  quiet_cycles;

  // Rounds a Q15 sum to nearest and clamps to the 18-bit range.
  function automatic logic signed [17:0] round_clamp(longint acc);
    longint q;
    q = (acc + 16384) >>> 15;
    if (q > 131071) q = 131071;
    if (q < -131072) q = -131072;
    return q[17:0];
  endfunction

  // Shifts one extended value into the window and records a pair on even phases.
  function automatic void shift_value(logic signed [15:0] v, int unsigned pos);
    longint hacc, lacc;
    tb_dwt10_pkg::coef_pair_t p;
    hacc = 0;
    lacc = 0;
    for (int t = dwt10_pkg::TAPS - 1; t > 0; t--) window[t] = window[t-1];
    window[0] = v;
    if (pos >= dwt10_pkg::TAPS && ((pos - dwt10_pkg::TAPS) % 2) == 0) begin
      for (int t = 0; t < dwt10_pkg::TAPS; t++) begin
        hacc += longint'(window[t]) * longint'(dwt10_pkg::HP_TAPS[t]);
        lacc += longint'(window[t]) * longint'(dwt10_pkg::LP_TAPS[t]);
      end
      p.high_coef  = round_clamp(hacc);
      p.low_coef   = round_clamp(lacc);
      p.coef_index = pair_cnt[15:0];
      p.final_res  = 1'b0;
      p.too_short  = 1'b0;
      pending_pairs.push_back(p);
      pair_cnt = (pair_cnt + 1) & 16'hFFFF;
    end
  endfunction

  // Works out every pair that one accepted sample releases.
  function automatic void predict_pairs(logic signed [15:0] s, logic lst);
    int unsigned j;
    int unsigned before_cnt;
    tb_dwt10_pkg::coef_pair_t p;
    j = taken_cnt;
    before_cnt = pending_pairs.size();
    if (j >= dwt10_pkg::MAX_LEN - 1) lst = 1'b1;
    for (int k = dwt10_pkg::MIRROR - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = s;
    if (j + 1 < dwt10_pkg::MIRROR) begin
      head_buf[j] = s;
      if (lst) begin
        p = '{18'sd0, 18'sd0, 16'd0, 1'b1, 1'b1};
        pending_pairs.push_back(p);
        taken_cnt = 0;
        pair_cnt = 0;
      end else begin
        taken_cnt = j + 1;
      end
      return;
    end
    if (j + 1 == dwt10_pkg::MIRROR) begin
      head_buf[j] = s;
      for (int k = 0; k < dwt10_pkg::MIRROR; k++)
        shift_value(head_buf[dwt10_pkg::MIRROR - 1 - k], k);
      for (int k = 0; k < dwt10_pkg::MIRROR; k++)
        shift_value(head_buf[k], dwt10_pkg::MIRROR + k);
    end else begin
      shift_value(s, j + dwt10_pkg::MIRROR);
    end
    if (lst) begin
      for (int k = 0; k < dwt10_pkg::MIRROR; k++)
        shift_value(recent[k], j + 1 + dwt10_pkg::MIRROR + k);
      if (pending_pairs.size() > before_cnt)
        pending_pairs[pending_pairs.size() - 1].final_res = 1'b1;
      taken_cnt = 0;
      pair_cnt = 0;
    end else begin
      taken_cnt = j + 1;
    end
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sends one item, with random bursts of idle cycles before it.
  task automatic send_sample(logic signed [15:0] s, logic lst);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.last   <= lst;
    do @(posedge clk); while (!in_ch.ready);
    predict_pairs(s, lst);
  endtask

  // Sends a signal of the given length with random content.
  task automatic send_signal(int unsigned len);
    logic signed [15:0] s;
    for (int unsigned k = 0; k < len; k++) begin
      case ($urandom_range(0, 5))
        0: s = 16'sh7FFF;
        1: s = 16'sh8000;
        2: s = $signed(16'($urandom_range(0, 255))) - 16'sd128;
        default: s = 16'($urandom);
      endcase
      send_sample(s, k == len - 1);
    end
  endtask

  // Stimulus.
  initial begin
    tb_dwt10_pkg::stim_row_t rows [$];
    tb_dwt10_pkg::stim_row_t r;
    tb_dwt10_pkg::coef_pair_t zero_pair;
    tb_dwt10_pkg::coef_pair_t got;
    tb_dwt10_pkg::coef_pair_t want;
    int unsigned len;
    zero_pair = '{18'sd0, 18'sd0, 16'd0, 1'b0, 1'b0};
    error_cnt = 0;
    stim_done = 1'b0;
    no_idle = 1'b0;
    taken_cnt = 0;
    pair_cnt = 0;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    in_ch.last <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a one-sample signal, then a three-sample signal, both too short,
    // then a 19-sample signal held at the positive limit.
    r = '{16'sh7FFF, 1'b1, 1'b1, '{18'sd0, 18'sd0, 16'd0, 1'b1, 1'b1}};
    rows.push_back(r);
    r = '{16'sh8000, 1'b0, 1'b0, zero_pair};
    rows.push_back(r);
    r = '{16'sh0001, 1'b0, 1'b0, zero_pair};
    rows.push_back(r);
    r = '{-16'sd1, 1'b1, 1'b1, '{18'sd0, 18'sd0, 16'd0, 1'b1, 1'b1}};
    rows.push_back(r);
    for (int k = 0; k < dwt10_pkg::MIRROR; k++) begin
      r = '{16'sh7FFF, k == dwt10_pkg::MIRROR - 1, 1'b0, zero_pair};
      rows.push_back(r);
    end
    foreach (rows[i]) begin
      if (rows[i].chk_first) begin
        wait (pending_pairs.size() == 0);
        send_sample(rows[i].sample, rows[i].last);
        got  = pending_pairs[0];
        want = rows[i].first_pair;
        if (got.high_coef !== want.high_coef || got.low_coef !== want.low_coef ||
            got.coef_index !== want.coef_index || got.final_res !== want.final_res ||
            got.too_short !== want.too_short) begin
          $error("directed row %0d: expected short-signal error result", i);
          error_cnt++;
        end
      end else begin
        send_sample(rows[i].sample, rows[i].last);
      end
    end

    // Random signals, mostly of moderate length, with a few short ones and one
    // negative-limit signal of exactly 20 samples; the last stretch runs without idling.
    for (int k = 0; k < 16; k++) begin
      if (k == 13) no_idle = 1'b1;
      case ($urandom_range(0, 4))
        0: len = $urandom_range(1, 18);
        1: len = $urandom_range(19, 21);
        default: len = $urandom_range(22, 45);
      endcase
      send_signal(len);
    end
    for (int k = 0; k < 20; k++) send_sample(16'sh8000, k == 19);
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random backpressure and the check against the oldest expectation.
  initial begin
    tb_dwt10_pkg::coef_pair_t exp_pair;
    int stall_left;
    out_ch.ready <= 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_pairs.size() == 0) begin
          $error("unexpected result, index %0d", out_ch.coef_index);
          error_cnt++;
        end else begin
          exp_pair = pending_pairs.pop_front();
          if (out_ch.high_coef !== exp_pair.high_coef) begin
            $error("high_coef: expected %0d, actual %0d", exp_pair.high_coef, out_ch.high_coef);
            error_cnt++;
          end
          if (out_ch.low_coef !== exp_pair.low_coef) begin
            $error("low_coef: expected %0d, actual %0d", exp_pair.low_coef, out_ch.low_coef);
            error_cnt++;
          end
          if (out_ch.coef_index !== exp_pair.coef_index) begin
            $error("coef_index: expected %0d, actual %0d",
                   exp_pair.coef_index, out_ch.coef_index);
            error_cnt++;
          end
          if (out_ch.final_res !== exp_pair.final_res) begin
            $error("final_res: expected %0d, actual %0d", exp_pair.final_res, out_ch.final_res);
            error_cnt++;
          end
          if (out_ch.too_short !== exp_pair.too_short) begin
            $error("too_short: expected %0d, actual %0d", exp_pair.too_short, out_ch.too_short);
            error_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // End of run and watchdog.
  initial begin
    quiet_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("dwt_db10_analysis_stage verification failed");
        $finish;
      end
      if (stim_done && pending_pairs.size() == 0) begin
        repeat (600) @(posedge clk);
        if (error_cnt == 0 && pending_pairs.size() == 0 && !out_ch.valid) begin
          $display("dwt_db10_analysis_stage verification clean");
        end else begin
          $display("dwt_db10_analysis_stage verification failed");
        end
        $finish;
      end
    end
  end
endmodule
